// File: design/mrmp_pkg.sv
// ----------------------------------------------------------------------------
// mrmp_pkg
// shared types, codes and constants of the midi receive merge parser
// ----------------------------------------------------------------------------
package mrmp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] CC_STATUS    = 8'hB0;
   localparam logic [7:0] REALTIME_MIN = 8'hF8;
   localparam logic [3:0] CC_NIBBLE    = 4'hB;
   localparam logic [2:0] VOICE_SYSTEM = 3'b111;
   localparam logic [2:0] VOICE_PROG   = 3'b100;
   localparam logic [2:0] VOICE_PRESS  = 3'b101;

   localparam logic [1:0] CSR_MERGE = 2'd0;
   localparam logic [1:0] CSR_HDR_A = 2'd1;
   localparam logic [1:0] CSR_HDR_B = 2'd2;

   typedef enum logic [2:0] {
      KIND_ECHO      = 3'd0,
      KIND_CC        = 3'd1,
      KIND_A_START   = 3'd2,
      KIND_A_PAYLOAD = 3'd3,
      KIND_A_END     = 3'd4,
      KIND_B_PAYLOAD = 3'd5,
      KIND_B_END     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] status;
      logic [6:0] number;
      logic [6:0] value;
   } evt_type;

   typedef struct packed {
      logic [1:0] count;
      evt_type    ev1;
      evt_type    ev0;
   } job_type;

   function automatic evt_type make_evt(kind_type k, logic [7:0] d, logic [7:0] st,
                                        logic [6:0] n, logic [6:0] v);
      evt_type e;
      e.kind   = k;
      e.data   = d;
      e.status = st;
      e.number = n;
      e.value  = v;
      return e;
   endfunction

endpackage

// File: design/mrmp_front.sv
// ----------------------------------------------------------------------------
// mrmp_front
// byte classifier: parser state, config registers and result job building
// ----------------------------------------------------------------------------
module mrmp_front
   import mrmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata,
   input  logic        queue_full,
   output logic        push,
   output job_type     job
);

   logic        merge_en_ff, merge_en_in;
   logic [23:0] hdr_a_ff, hdr_a_in;
   logic [23:0] hdr_b_ff, hdr_b_in;
   logic        merging_ff, merging_in;
   logic [1:0]  remain_ff, remain_in;
   logic        insx_ff, insx_in;
   logic [1:0]  sxcnt_ff, sxcnt_in;
   logic [7:0]  hdr0_ff, hdr0_in;
   logic [7:0]  hdr1_ff, hdr1_in;
   logic        disc_ff, disc_in;
   logic        va_ff, va_in;
   logic        vb_ff, vb_in;
   logic        cc_coll_ff, cc_coll_in;
   logic [1:0]  cc_idx_ff, cc_idx_in;
   logic [7:0]  last_ff, last_in;
   logic [6:0]  d0_ff, d0_in;

   logic        accept;
   logic        pre_v, echo_v, post_v;
   evt_type     pre_e, echo_e, post_e;
   logic [7:0]  b;

   assign b          = req_tdata;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      merging_in = merging_ff;
      remain_in  = remain_ff;
      insx_in    = insx_ff;
      sxcnt_in   = sxcnt_ff;
      hdr0_in    = hdr0_ff;
      hdr1_in    = hdr1_ff;
      disc_in    = disc_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      cc_coll_in = cc_coll_ff;
      cc_idx_in  = cc_idx_ff;
      last_in    = last_ff;
      d0_in      = d0_ff;
      pre_v      = 1'b0;
      echo_v     = 1'b0;
      post_v     = 1'b0;
      echo_e     = make_evt(KIND_ECHO, b, 8'd0, 7'd0, 7'd0);
      pre_e      = make_evt(va_ff ? KIND_A_END : KIND_B_END, 8'd0, 8'd0, 7'd0, 7'd0);
      post_e     = pre_e;
      if (b >= REALTIME_MIN) begin
         echo_v = merge_en_ff;
      end else if (b[7]) begin
         cc_coll_in = 1'b0;
         last_in    = b;
         if (b == SYSEX_START) begin
            pre_v    = insx_ff && (va_ff || vb_ff);
            disc_in  = 1'b0;
            va_in    = 1'b0;
            vb_in    = 1'b0;
            insx_in  = 1'b1;
            sxcnt_in = 2'd0;
            if (merge_en_ff) begin
               merging_in = 1'b1;
               echo_v     = 1'b1;
            end
         end else begin
            // listed channel-1 voice status
            if (merge_en_ff && b[3:0] == 4'd0 && b[6:4] != VOICE_SYSTEM) begin
               merging_in = 1'b1;
               remain_in  = (b[6:4] == VOICE_PROG || b[6:4] == VOICE_PRESS) ? 2'd1 : 2'd2;
               echo_v     = 1'b1;
            end
            if (b == SYSEX_END) begin
               if (merge_en_ff) begin
                  merging_in = 1'b0;
                  echo_v     = 1'b1;
               end
               if (insx_ff) begin
                  post_v = va_ff || vb_ff;
                  va_in  = 1'b0;
                  vb_in  = 1'b0;
               end
               insx_in = 1'b0;
            end else if (b == CC_STATUS) begin
               cc_coll_in = 1'b1;
               cc_idx_in  = 2'd1;
            end
         end
      end else begin
         if (merge_en_ff && merging_ff) begin
            echo_v = 1'b1;
            if (!insx_ff) begin
               if (remain_ff <= 2'd1) begin
                  remain_in  = 2'd0;
                  merging_in = 1'b0;
               end else begin
                  remain_in = remain_ff - 2'd1;
               end
            end
         end
         if (insx_ff) begin
            if (!disc_ff) begin
               case (sxcnt_ff)
                  2'd0: hdr0_in = b;
                  2'd1: hdr1_in = b;
                  2'd2: begin
                     if ({hdr0_ff, hdr1_ff, b} == hdr_a_ff) begin
                        va_in  = 1'b1;
                        post_v = 1'b1;
                        post_e = make_evt(KIND_A_START, 8'd0, 8'd0, 7'd0, 7'd0);
                     end else if ({hdr0_ff, hdr1_ff, b} == hdr_b_ff) begin
                        vb_in = 1'b1;
                     end else begin
                        disc_in = 1'b1;
                     end
                  end
                  default: begin
                     post_v = va_ff || vb_ff;
                     post_e = make_evt(va_ff ? KIND_A_PAYLOAD : KIND_B_PAYLOAD, b, 8'd0,
                                       7'd0, 7'd0);
                  end
               endcase
            end
            if (sxcnt_ff != 2'd3) begin
               sxcnt_in = sxcnt_ff + 2'd1;
            end
         end else begin
            // running status
            if (!cc_coll_ff && last_ff[7:4] == CC_NIBBLE) begin
               cc_coll_in = 1'b1;
               cc_idx_in  = 2'd1;
            end
            if (cc_coll_in) begin
               if (cc_idx_in == 2'd1) begin
                  d0_in     = b[6:0];
                  cc_idx_in = 2'd2;
               end else begin
                  cc_coll_in = 1'b0;
                  cc_idx_in  = 2'd0;
                  post_v     = 1'b1;
                  post_e     = make_evt(KIND_CC, 8'd0, last_ff, d0_ff, b[6:0]);
               end
            end
         end
      end
   end

   // order: sysex end before echo on start, echo before everything else
   always_comb begin
      job.count = {1'b0, pre_v} + {1'b0, echo_v} + {1'b0, post_v};
      job.ev0   = pre_v ? pre_e : (echo_v ? echo_e : post_e);
      job.ev1   = pre_v ? echo_e : post_e;
   end

   assign push = accept && (job.count != 2'd0);

   always_comb begin
      merge_en_in = merge_en_ff;
      hdr_a_in    = hdr_a_ff;
      hdr_b_in    = hdr_b_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MERGE: merge_en_in = csr_wdata[0];
            CSR_HDR_A: hdr_a_in    = csr_wdata;
            CSR_HDR_B: hdr_b_in    = csr_wdata;
            default:   merge_en_in = merge_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_en_ff <= 1'b0;
         hdr_a_ff    <= 24'd0;
         hdr_b_ff    <= 24'd0;
         merging_ff  <= 1'b0;
         remain_ff   <= 2'd0;
         insx_ff     <= 1'b0;
         sxcnt_ff    <= 2'd0;
         disc_ff     <= 1'b0;
         va_ff       <= 1'b0;
         vb_ff       <= 1'b0;
         cc_coll_ff  <= 1'b0;
         cc_idx_ff   <= 2'd0;
         last_ff     <= 8'd0;
      end else begin
         merge_en_ff <= merge_en_in;
         hdr_a_ff    <= hdr_a_in;
         hdr_b_ff    <= hdr_b_in;
         if (accept) begin
            merging_ff <= merging_in;
            remain_ff  <= remain_in;
            insx_ff    <= insx_in;
            sxcnt_ff   <= sxcnt_in;
            disc_ff    <= disc_in;
            va_ff      <= va_in;
            vb_ff      <= vb_in;
            cc_coll_ff <= cc_coll_in;
            cc_idx_ff  <= cc_idx_in;
            last_ff    <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
         d0_ff   <= d0_in;
      end
   end

endmodule

// File: design/mrmp_queue.sv
// ----------------------------------------------------------------------------
// mrmp_queue
// small job queue between the classifier and the result sequencer
// ----------------------------------------------------------------------------
module mrmp_queue
   import mrmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/mrmp_back.sv
// ----------------------------------------------------------------------------
// mrmp_back
// result sequencer: sends the one or two results of each queued job
// ----------------------------------------------------------------------------
module mrmp_back
   import mrmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic    idx_ff, idx_in;
   evt_type cur;
   logic    xfer;

   assign cur        = idx_ff ? head_job.ev1 : head_job.ev0;
   assign rsp_tvalid = head_valid;
   assign rsp_tlast  = (head_job.count == ({1'b0, idx_ff} + 2'd1));
   assign rsp_tuser  = cur.kind;
   assign rsp_tdata  = {2'b00, cur.value, cur.number, cur.status, cur.data};
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && rsp_tlast;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: design/midi_rx_merge_parser_core.sv
// a result is written into the job queue when its byte is taken on req and
//   is sent on rsp from the queue head; throughput: one byte per cycle into
//   a two-job queue; the sequencer sends one result per cycle unless rsp stalls
// req_tready drops only while the job queue is full
// reset (synchronous, active high) clears parser state, config and the queue
// ----------------------------------------------------------------------------
// midi_rx_merge_parser_core
// midi receive parser with merge echo, control-change assembly and vendor
// sysex framing
// ----------------------------------------------------------------------------
module midi_rx_merge_parser_core
   import mrmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // data_byte, cc_status, cc_number, cc_value
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   mrmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   mrmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   mrmp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/mrmp_checker.sv
// ----------------------------------------------------------------------------
// mrmp_checker
// port-level checks of the midi receive merge parser
// ----------------------------------------------------------------------------
module mrmp_checker
   import mrmp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7)
      else $error("undefined event kind");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_CC) ? (rsp_tdata[7:0] == 8'd0) :
                     (rsp_tdata[31:8] == 24'd0))
      else $error("unused result fields not zero");

   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CC || rsp_tuser == KIND_A_START) |-> rsp_tlast)
      else $error("cc or vendor start not last of run");

endmodule

bind midi_rx_merge_parser_core mrmp_checker u_checker (.*);
